// ===== hdl/gitc_pkg.sv =====
package gitc_pkg;

    // Field widths
    localparam int OpW       = 1;
    localparam int DegW      = 10;
    localparam int RateW     = 20;
    localparam int TimeW     = 32;
    localparam int SpeedW    = 10;
    localparam int MinMsW    = 16;
    localparam int DriveW    = 11;
    localparam int AngleW    = 32;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    // Integration datapath widths
    localparam int SumW      = RateW + 1;
    localparam int DeltaW    = 16;
    localparam int MagW      = 36;
    localparam int ProdW     = SumW + DeltaW;
    localparam int TruncW    = 32;
    localparam int HalfW     = TruncW / 2;
    localparam int RecipW    = 29;
    localparam int PpW       = HalfW + RecipW;
    localparam int FullW     = PpW + HalfW;
    localparam int RecipShift = 35;
    localparam int QuoW      = FullW - RecipShift;
    localparam int IncW      = QuoW + 1;
    localparam int ErrW      = AngleW + 2;

    // Round-to-nearest bias for the divide by 2000, and the reciprocal of 125
    // scaled by 2^35 (the remaining factor 16 is taken out by a shift)
    localparam logic [MagW-1:0]   RoundBias = MagW'(1000);
    localparam logic [RecipW-1:0] Recip     = RecipW'(274877907);

    typedef enum logic [OpW-1:0] {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FULL_SPEED   = 3'd0,
        CFG_CORR_SPEED   = 3'd1,
        CFG_SLOW_ZONE    = 3'd2,
        CFG_DONE_TOL     = 3'd3,
        CFG_MIN_TURN_MS  = 3'd4
    } cfg_idx_t;

    // Per-word control carried down the pipeline
    typedef struct packed {
        logic            is_start;
        logic            proc;
        logic            time_ok;
        logic [DegW-1:0] goal;
    } item_ctl_t;

endpackage

// ===== hdl/gitc_ifs.sv =====
interface gitc_in_if;
    logic                               valid;
    logic                               ready;
    logic [gitc_pkg::OpW-1:0]           operation;
    logic [gitc_pkg::DegW-1:0]          target_degrees;
    logic signed [gitc_pkg::RateW-1:0]  rate_z;
    logic [gitc_pkg::TimeW-1:0]         time_ms;

    modport source (output valid, output operation, output target_degrees,
                    output rate_z, output time_ms, input ready);
    modport sink   (input valid, input operation, input target_degrees,
                    input rate_z, input time_ms, output ready);
endinterface

interface gitc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [gitc_pkg::DriveW-1:0] drive_left;
    logic signed [gitc_pkg::DriveW-1:0] drive_right;
    logic signed [gitc_pkg::AngleW-1:0] angle_turned;
    logic                               done_res;

    modport source (output valid, output drive_left, output drive_right,
                    output angle_turned, output done_res, input ready);
    modport sink   (input valid, input drive_left, input drive_right,
                    input angle_turned, input done_res, output ready);
endinterface

interface gitc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gitc_pkg::CfgIdxW-1:0]      index;
    logic [gitc_pkg::CfgDataW-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gyro_integrating_turn_controller_unit.sv =====
// An accepted input word passes s1, s2, s3 and s4 into the result register.
// Throughput: one word per cycle unless the result port stalls; the accumulator add
// and finish decision close in a single stage, so back-to-back samples never
// wait on each other. Divide by 2000: two 16x29 partial products in s3, summed
// in s4. Reset (rst_n low, asynchronous): registers, accumulator and pipeline
// clear, the controller is idle and samples are dropped until a start word.
module gyro_integrating_turn_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    gitc_in_if.sink     sample_in,
    gitc_out_if.source  result_out,
    gitc_cfg_if.sink    cfg
);

    // Configuration registers
    logic [gitc_pkg::SpeedW-1:0] full_speed_reg;
    logic [gitc_pkg::SpeedW-1:0] corr_speed_reg;
    logic [gitc_pkg::DegW-1:0]   slow_zone_reg;
    logic [gitc_pkg::DegW-1:0]   done_tol_reg;
    logic [gitc_pkg::MinMsW-1:0] min_turn_ms_reg;

    // Front-end copy of the sample history, tracked from the input stream
    logic [gitc_pkg::RateW-1:0]  last_rate_reg;
    logic [gitc_pkg::TimeW-1:0]  last_time_reg;
    logic [gitc_pkg::TimeW-1:0]  begin_time_reg;
    logic [gitc_pkg::DegW-1:0]   goal_reg;

    // Pipeline stages
    logic                          s1_valid_reg;
    gitc_pkg::item_ctl_t           s1_ctl_reg;
    logic [gitc_pkg::SumW-1:0]     s1_abs_sum_reg;
    logic                          s1_neg_reg;
    logic [gitc_pkg::DeltaW-1:0]   s1_delta_reg;

    logic                          s2_valid_reg;
    gitc_pkg::item_ctl_t           s2_ctl_reg;
    logic [gitc_pkg::MagW-1:0]     s2_mag_reg;
    logic                          s2_neg_reg;

    logic                          s3_valid_reg;
    gitc_pkg::item_ctl_t           s3_ctl_reg;
    logic [gitc_pkg::PpW-1:0]      s3_pp_hi_reg;
    logic [gitc_pkg::PpW-1:0]      s3_pp_lo_reg;
    logic                          s3_neg_reg;

    logic                          s4_valid_reg;
    gitc_pkg::item_ctl_t           s4_ctl_reg;
    logic [gitc_pkg::IncW-1:0]     s4_inc_reg;

    // Turn state
    logic [gitc_pkg::AngleW-1:0]   turned_acc_reg;
    logic                          turning_reg;

    // Result register
    logic                          res_valid_reg;
    logic [gitc_pkg::DriveW-1:0]   res_drive_left_reg;
    logic [gitc_pkg::DriveW-1:0]   res_drive_right_reg;
    logic [gitc_pkg::AngleW-1:0]   res_angle_reg;
    logic                          res_done_reg;

    // Handshake chain
    logic out_free;
    logic emit4;
    logic take4;
    logic adv4;
    logic adv3;
    logic adv2;
    logic adv1;
    logic accept_in;

    // Stage 1 combinational
    logic                        in_start;
    logic [gitc_pkg::TimeW-1:0]  time_diff;
    logic                        new_time;
    logic [gitc_pkg::DeltaW-1:0] delta;
    logic [gitc_pkg::SumW-1:0]   rate_sum;
    logic [gitc_pkg::SumW-1:0]   abs_sum;
    logic [gitc_pkg::TimeW-1:0]  elapsed;
    gitc_pkg::item_ctl_t         in_ctl;

    // Stage 2..4 combinational
    logic [gitc_pkg::ProdW-1:0]  mag_prod;
    logic [gitc_pkg::MagW-1:0]   mag_round;
    logic [gitc_pkg::TruncW-1:0] mag_trunc;
    logic [gitc_pkg::FullW-1:0]  recip_full;
    logic [gitc_pkg::QuoW-1:0]   quo;
    logic [gitc_pkg::IncW-1:0]   quo_ext;

    // Stage 5 combinational
    logic [gitc_pkg::AngleW:0]   acc_sum;
    logic [gitc_pkg::AngleW-1:0] acc_sat;
    logic [gitc_pkg::ErrW-1:0]   goal_ext;
    logic [gitc_pkg::ErrW-1:0]   err;
    logic [gitc_pkg::ErrW-1:0]   err_mag;
    logic [gitc_pkg::ErrW-1:0]   slow_lim;
    logic                        start_done;
    logic                        sample_done;
    logic [gitc_pkg::DriveW-1:0] sample_drive;
    logic [gitc_pkg::DriveW-1:0] drive_next;
    logic [gitc_pkg::AngleW-1:0] angle_next;
    logic                        done_next;
    logic [gitc_pkg::AngleW-1:0] acc_next;
    logic                        turning_next;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_speed_reg  <= '0;
            corr_speed_reg  <= '0;
            slow_zone_reg   <= '0;
            done_tol_reg    <= '0;
            min_turn_ms_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (gitc_pkg::cfg_idx_t'(cfg.index))
                gitc_pkg::CFG_FULL_SPEED:  full_speed_reg  <= cfg.data[gitc_pkg::SpeedW-1:0];
                gitc_pkg::CFG_CORR_SPEED:  corr_speed_reg  <= cfg.data[gitc_pkg::SpeedW-1:0];
                gitc_pkg::CFG_SLOW_ZONE:   slow_zone_reg   <= cfg.data[gitc_pkg::DegW-1:0];
                gitc_pkg::CFG_DONE_TOL:    done_tol_reg    <= cfg.data[gitc_pkg::DegW-1:0];
                gitc_pkg::CFG_MIN_TURN_MS: min_turn_ms_reg <= cfg.data[gitc_pkg::MinMsW-1:0];
                default:                   ;
            endcase
        end
    end

    // Advance stages whenever the next one is empty or moving
    assign out_free  = !res_valid_reg || result_out.ready;
    assign emit4     = s4_ctl_reg.is_start || (turning_reg && s4_ctl_reg.proc);
    assign take4     = s4_valid_reg && (!emit4 || out_free);
    assign adv4      = !s4_valid_reg || take4;
    assign adv3      = !s3_valid_reg || adv4;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign sample_in.ready = adv1;
    assign accept_in = sample_in.valid && adv1;

    // Stage 1: time delta, rate sum and elapsed check against the history
    always_comb
    begin
        in_start  = (gitc_pkg::op_t'(sample_in.operation) == gitc_pkg::OP_START);
        time_diff = sample_in.time_ms - last_time_reg;
        new_time  = (sample_in.time_ms != last_time_reg);
        delta     = (|time_diff[gitc_pkg::TimeW-1:gitc_pkg::DeltaW]) ? '1
                                                               : time_diff[gitc_pkg::DeltaW-1:0];
        rate_sum  = {sample_in.rate_z[gitc_pkg::RateW-1], sample_in.rate_z}
                  + {last_rate_reg[gitc_pkg::RateW-1], last_rate_reg};
        abs_sum   = rate_sum[gitc_pkg::SumW-1] ? (-rate_sum) : rate_sum;
        elapsed   = sample_in.time_ms - begin_time_reg;
        in_ctl.is_start = in_start;
        in_ctl.proc     = !in_start && new_time;
        in_ctl.time_ok  = (elapsed >= {{(gitc_pkg::TimeW-gitc_pkg::MinMsW){1'b0}},
                                       min_turn_ms_reg});
        in_ctl.goal     = in_start ? sample_in.target_degrees : goal_reg;
    end

    // Track the last sample; words ignored downstream are harmless here
    // because the next start overwrites all of it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rate_reg  <= '0;
            last_time_reg  <= '0;
            begin_time_reg <= '0;
            goal_reg       <= '0;
        end
        else if (accept_in)
        begin
            if (in_start)
            begin
                last_rate_reg  <= sample_in.rate_z;
                last_time_reg  <= sample_in.time_ms;
                begin_time_reg <= sample_in.time_ms;
                goal_reg       <= sample_in.target_degrees;
            end
            else if (new_time)
            begin
                last_rate_reg <= sample_in.rate_z;
                last_time_reg <= sample_in.time_ms;
            end
        end
    end

    // Stage 2..4 datapath
    assign mag_prod  = s1_abs_sum_reg * s1_delta_reg;
    assign mag_round = s2_mag_reg + gitc_pkg::RoundBias;
    assign mag_trunc = mag_round[gitc_pkg::MagW-1:gitc_pkg::MagW-gitc_pkg::TruncW];
    assign recip_full = {s3_pp_hi_reg, {gitc_pkg::HalfW{1'b0}}}
                      + {{gitc_pkg::HalfW{1'b0}}, s3_pp_lo_reg};
    assign quo       = recip_full[gitc_pkg::FullW-1:gitc_pkg::RecipShift];
    assign quo_ext   = {1'b0, quo};

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= sample_in.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_ctl_reg     <= in_ctl;
            s1_abs_sum_reg <= abs_sum;
            s1_neg_reg     <= rate_sum[gitc_pkg::SumW-1];
            s1_delta_reg   <= delta;
        end
        if (adv2)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            s2_mag_reg <= mag_prod[gitc_pkg::MagW-1:0];
            s2_neg_reg <= s1_neg_reg;
        end
        if (adv3)
        begin
            s3_ctl_reg   <= s2_ctl_reg;
            s3_pp_hi_reg <= mag_trunc[gitc_pkg::TruncW-1:gitc_pkg::HalfW] * gitc_pkg::Recip;
            s3_pp_lo_reg <= mag_trunc[gitc_pkg::HalfW-1:0] * gitc_pkg::Recip;
            s3_neg_reg   <= s2_neg_reg;
        end
        if (adv4)
        begin
            s4_ctl_reg <= s3_ctl_reg;
            s4_inc_reg <= s3_neg_reg ? (-quo_ext) : quo_ext;
        end
    end

    // Stage 5: accumulate, check finish and pick the drive
    always_comb
    begin
        acc_sum = {{(gitc_pkg::AngleW+1-gitc_pkg::IncW){s4_inc_reg[gitc_pkg::IncW-1]}},
                   s4_inc_reg}
                + {turned_acc_reg[gitc_pkg::AngleW-1], turned_acc_reg};
        if (acc_sum[gitc_pkg::AngleW] != acc_sum[gitc_pkg::AngleW-1])
        begin
            acc_sat = acc_sum[gitc_pkg::AngleW] ? {1'b1, {(gitc_pkg::AngleW-1){1'b0}}}
                                                : {1'b0, {(gitc_pkg::AngleW-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[gitc_pkg::AngleW-1:0];
        end

        goal_ext = {{(gitc_pkg::ErrW-gitc_pkg::DegW-8){1'b0}}, s4_ctl_reg.goal, 8'b0};
        err      = goal_ext - {{2{acc_sat[gitc_pkg::AngleW-1]}}, acc_sat};
        err_mag  = err[gitc_pkg::ErrW-1] ? (-err) : err;
        slow_lim = {{(gitc_pkg::ErrW-gitc_pkg::DegW-8){1'b0}}, slow_zone_reg, 8'b0};

        sample_done = (err_mag[gitc_pkg::ErrW-1:8]
                       <= {{(gitc_pkg::ErrW-8-gitc_pkg::DegW){1'b0}}, done_tol_reg})
                   && s4_ctl_reg.time_ok;
        start_done  = (s4_ctl_reg.goal <= done_tol_reg) && (min_turn_ms_reg == '0);

        if ($signed(err) > $signed(slow_lim))
        begin
            sample_drive = {1'b0, full_speed_reg};
        end
        else if (!err[gitc_pkg::ErrW-1] && (err != '0))
        begin
            sample_drive = {1'b0, corr_speed_reg};
        end
        else
        begin
            sample_drive = -{1'b0, corr_speed_reg};
        end

        if (s4_ctl_reg.is_start)
        begin
            done_next    = start_done;
            drive_next   = start_done ? '0 : {1'b0, full_speed_reg};
            angle_next   = '0;
            acc_next     = '0;
            turning_next = !start_done;
        end
        else
        begin
            done_next    = sample_done;
            drive_next   = sample_done ? '0 : sample_drive;
            angle_next   = acc_sat;
            acc_next     = acc_sat;
            turning_next = !sample_done;
        end
    end

    // Commit turn state when a word produces its result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turned_acc_reg <= '0;
            turning_reg    <= 1'b0;
        end
        else if (take4 && emit4)
        begin
            turned_acc_reg <= acc_next;
            turning_reg    <= turning_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take4 && emit4)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take4 && emit4)
        begin
            res_drive_left_reg  <= drive_next;
            res_drive_right_reg <= -drive_next;
            res_angle_reg       <= angle_next;
            res_done_reg        <= done_next;
        end
    end

    assign result_out.valid        = res_valid_reg;
    assign result_out.drive_left   = res_drive_left_reg;
    assign result_out.drive_right  = res_drive_right_reg;
    assign result_out.angle_turned = res_angle_reg;
    assign result_out.done_res     = res_done_reg;

    // A finished turn never drives the motors
    a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_done_reg |-> (res_drive_left_reg == '0))
        else $error("done result with nonzero drive");

    // A finishing word leaves the controller idle
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        take4 && emit4 && done_next |=> !turning_reg)
        else $error("turn still active after done result");

    // An empty first stage always takes a word
    a_front_open: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample_in.ready)
        else $error("input stalled with empty front stage");

endmodule

// ===== dv/tb_gyro_integrating_turn_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_gyro_integrating_turn_controller_unit;
    import gitc_pkg::*;

    localparam logic signed [RateW-1:0] RateMax = {1'b0, {(RateW-1){1'b1}}};
    localparam logic signed [RateW-1:0] RateMin = {1'b1, {(RateW-1){1'b0}}};
    localparam longint AccMax = 64'sh0000_0000_7FFF_FFFF;
    localparam longint AccMin = -AccMax - 1;
    localparam longint TrapDiv = 2000;
    localparam longint DeltaCap = 65535;
    localparam int ResultsPerPhase = 90;
    localparam int PhaseCount = 8;
    localparam int SettleCycles = 12;

    typedef enum {FLOW_OPEN, FLOW_CHOPPY, FLOW_STARVED} stall_mode_t;

    typedef struct {
        logic signed [DriveW-1:0] drive_left;
        logic signed [DriveW-1:0] drive_right;
        logic signed [AngleW-1:0] angle_turned;
        logic                     done_res;
    } turn_word_t;

    // Tracks the turn controller state and the drive words it should emit
    class turn_predictor;
        logic [SpeedW-1:0]        full_speed;
        logic [SpeedW-1:0]        corr_speed;
        logic [DegW-1:0]          slow_zone;
        logic [DegW-1:0]          done_tol;
        logic [MinMsW-1:0]        min_turn_ms;
        logic signed [AngleW-1:0] turned_acc;
        logic signed [RateW-1:0]  last_rate;
        logic [TimeW-1:0]         last_time;
        logic [TimeW-1:0]         begin_time;
        logic [DegW-1:0]          goal_angle;
        bit                       turning;
        turn_word_t               expected_drive_q[$];
        int errors, n_checked, n_results, n_starts, n_samples, n_ignored;
        int n_finished, n_clipped, n_writes;

        function new();
            full_speed = '0; corr_speed = '0; slow_zone = '0; done_tol = '0;
            min_turn_ms = '0; turned_acc = '0; last_rate = '0; last_time = '0;
            begin_time = '0; goal_angle = '0; turning = 1'b0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100)
                $display("%0t ns mismatch: %s", $time, what);
        endtask

        function void set_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
            n_writes++;
            case (idx)
                CFG_FULL_SPEED:  full_speed  = value[SpeedW-1:0];
                CFG_CORR_SPEED:  corr_speed  = value[SpeedW-1:0];
                CFG_SLOW_ZONE:   slow_zone   = value[DegW-1:0];
                CFG_DONE_TOL:    done_tol    = value[DegW-1:0];
                CFG_MIN_TURN_MS: min_turn_ms = value[MinMsW-1:0];
                default: ;
            endcase
        endfunction

        function longint error_units();
            return longint'(goal_angle) * 256 - longint'(turned_acc);
        endfunction

        function void push_word(longint drive, longint angle, bit done);
            turn_word_t w;
            w.drive_left   = DriveW'(drive);
            w.drive_right  = DriveW'(-drive);
            w.angle_turned = AngleW'(angle);
            w.done_res     = done;
            expected_drive_q.push_back(w);
            n_results++;
            if (done)
                n_finished++;
        endfunction

        // Advance the controller by one accepted word
        function void note_word(op_t op, logic [DegW-1:0] target,
                                logic signed [RateW-1:0] rate, logic [TimeW-1:0] stamp);
            logic [TimeW-1:0] diff;
            logic [TimeW-1:0] elapsed;
            longint delta, prod, mag, q, acc, err, whole, drive;
            if (op == OP_START)
            begin
                n_starts++;
                goal_angle = target;
                last_rate  = rate;
                last_time  = stamp;
                begin_time = stamp;
                turned_acc = '0;
                if (target <= done_tol && min_turn_ms == 0)
                begin
                    turning = 1'b0;
                    push_word(0, 0, 1'b1);
                end
                else
                begin
                    turning = 1'b1;
                    push_word(longint'(full_speed), 0, 1'b0);
                end
                return;
            end
            if (!turning || stamp == last_time)
            begin
                n_ignored++;
                return;
            end
            n_samples++;
            // trapezoid step, rounded to nearest with ties away from zero
            diff  = stamp - last_time;
            delta = (diff > TimeW'(DeltaCap)) ? DeltaCap : longint'(diff);
            prod  = (longint'(last_rate) + longint'(rate)) * delta;
            mag   = (prod < 0) ? -prod : prod;
            q     = (mag + TrapDiv / 2) / TrapDiv;
            acc   = longint'(turned_acc) + ((prod < 0) ? -q : q);
            if (acc > AccMax || acc < AccMin)
                n_clipped++;
            if (acc > AccMax)
                acc = AccMax;
            if (acc < AccMin)
                acc = AccMin;
            turned_acc = AngleW'(acc);
            last_rate  = rate;
            last_time  = stamp;
            err     = longint'(goal_angle) * 256 - acc;
            whole   = ((err < 0) ? -err : err) / 256;
            elapsed = stamp - begin_time;
            if (whole <= longint'(done_tol) && elapsed >= TimeW'(min_turn_ms))
            begin
                turning = 1'b0;
                push_word(0, acc, 1'b1);
                return;
            end
            if (err > longint'(slow_zone) * 256)
                drive = longint'(full_speed);
            else if (err > 0)
                drive = longint'(corr_speed);
            else
                drive = -longint'(corr_speed);
            push_word(drive, acc, 1'b0);
        endfunction

        // Compare one result word against the oldest expected word
        task check_word(turn_word_t got);
            turn_word_t want;
            if (expected_drive_q.size() == 0)
            begin
                report($sformatf("unexpected result word, drive %0d angle %0d done %0b",
                                 got.drive_left, got.angle_turned, got.done_res));
                return;
            end
            want = expected_drive_q.pop_front();
            n_checked++;
            if (got.drive_left !== want.drive_left)
                report($sformatf("drive_left %0d, want %0d", got.drive_left, want.drive_left));
            if (got.drive_right !== want.drive_right)
                report($sformatf("drive_right %0d, want %0d",
                                 got.drive_right, want.drive_right));
            if (got.angle_turned !== want.angle_turned)
                report($sformatf("angle_turned %0d, want %0d",
                                 got.angle_turned, want.angle_turned));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
        endtask
    endclass

    logic clk;
    logic rst_n;

    gitc_in_if  sample_bus();
    gitc_out_if result_bus();
    gitc_cfg_if cfg_bus();

    gyro_integrating_turn_controller_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_bus),
        .result_out (result_bus),
        .cfg        (cfg_bus)
    );

    turn_predictor pred = new();
    turn_word_t    seen;
    int            holdoff_req;
    int            burst_left;
    logic [TimeW-1:0] now_ms;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: alternate stall patterns, honor long hold-off requests
    initial
    begin : receiver
        stall_mode_t mode;
        int mode_left;
        int hold_left;
        mode = FLOW_OPEN;
        mode_left = 0;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_req != 0)
            begin
                hold_left = holdoff_req;
                holdoff_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(8, 120);
                end
                mode_left--;
                case (mode)
                    FLOW_OPEN:    result_bus.ready <= 1'b1;
                    FLOW_CHOPPY:  result_bus.ready <= 1'($urandom_range(0, 1));
                    default:      result_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check every result word that is handed over
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.drive_left   = result_bus.drive_left;
            seen.drive_right  = result_bus.drive_right;
            seen.angle_turned = result_bus.angle_turned;
            seen.done_res     = result_bus.done_res;
            pred.check_word(seen);
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        pred.set_reg(idx, value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_word(op_t op, logic [DegW-1:0] target,
                             logic signed [RateW-1:0] rate, logic [TimeW-1:0] stamp);
        @(negedge clk);
        sample_bus.valid          <= 1'b1;
        sample_bus.operation      <= op;
        sample_bus.target_degrees <= target;
        sample_bus.rate_z         <= rate;
        sample_bus.time_ms        <= stamp;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        pred.note_word(op, target, rate, stamp);
    endtask

    // Sender pacing: bursts of words separated by random gaps
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                sample_bus.valid <= 1'b0;
            end
        end
    endtask

    // Stop sending and hold until every expected word is back
    task automatic wait_drained();
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pred.expected_drive_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles)
            @(posedge clk);
    endtask

    task automatic program_phase(int p);
        logic [CfgDataW-1:0] full, corr, zone, tol, min_ms;
        if (p == 0)
        begin
            full = 16'd1023; corr = 16'd1023; zone = 16'd1023; tol = 16'd1023;
            min_ms = 16'hFFFF;
        end
        else if (p == 1)
        begin
            full = '0; corr = '0; zone = '0; tol = '0; min_ms = '0;
        end
        else
        begin
            full   = CfgDataW'($urandom_range(0, 1023));
            corr   = CfgDataW'($urandom_range(0, 1023));
            zone   = ($urandom_range(0, 4) == 0) ? CfgDataW'($urandom_range(0, 1023))
                                                 : CfgDataW'($urandom_range(0, 40));
            tol    = ($urandom_range(0, 5) == 0) ? CfgDataW'($urandom_range(0, 1023))
                                                 : CfgDataW'($urandom_range(0, 4));
            min_ms = ($urandom_range(0, 5) == 0) ? CfgDataW'($urandom_range(0, 65535))
                                                 : CfgDataW'($urandom_range(0, 150));
        end
        write_reg(CFG_FULL_SPEED, full);
        write_reg(CFG_CORR_SPEED, corr);
        write_reg(CFG_SLOW_ZONE, zone);
        write_reg(CFG_DONE_TOL, tol);
        write_reg(CFG_MIN_TURN_MS, min_ms);
    endtask

    // One turn: a start, then samples steered toward the goal until it finishes,
    // with duplicate stamps, clock jumps, backward stamps and stray words mixed in
    task automatic run_turn(int unsigned max_samples, int runaway_dir);
        logic [DegW-1:0]         target;
        logic signed [RateW-1:0] rate;
        logic [TimeW-1:0]        stamp;
        op_t                     op;
        int unsigned step, pick, k, delta, eff;
        longint r;
        case ($urandom_range(0, 9))
            0:       target = '0;
            1:       target = '1;
            2:       target = DegW'($urandom_range(0, 1023));
            default: target = DegW'($urandom_range(1, 360));
        endcase
        if (runaway_dir > 0)
            rate = RateMax;
        else if (runaway_dir < 0)
            rate = RateMin;
        else
            rate = RateW'(longint'($urandom_range(0, 8000)) - 4000);
        send_word(OP_START, target, rate, now_ms);
        pace();
        step = 0;
        while (pred.turning && step < max_samples)
        begin
            step++;
            pick = $urandom_range(0, 99);
            if (runaway_dir != 0)
            begin
                now_ms += $urandom_range(65536, 300000);
                send_word(OP_SAMPLE, DegW'($urandom), rate, now_ms);
            end
            else if (pick < 4)
            begin
                op    = op_t'($urandom_range(0, 1));
                stamp = $urandom;
                send_word(op, DegW'($urandom), RateW'($urandom), stamp);
                now_ms = stamp;
            end
            else
            begin
                if (pick < 8)
                    delta = 0;
                else if (pick < 11)
                    delta = $urandom_range(65536, 1000000);
                else if (pick < 14)
                    delta = 32'd0 - $urandom_range(1, 50);
                else
                    delta = $urandom_range(1, 20);
                eff = (delta > 65535) ? 65535 : ((delta == 0) ? 1 : delta);
                k   = $urandom_range(1, 6);
                r   = pred.error_units() * TrapDiv / (longint'(eff) * k)
                      - longint'(pred.last_rate) + longint'($urandom_range(0, 6000)) - 3000;
                if (r > longint'(RateMax))
                    r = longint'(RateMax);
                if (r < longint'(RateMin))
                    r = longint'(RateMin);
                now_ms += delta;
                send_word(OP_SAMPLE, DegW'($urandom), RateW'(r), now_ms);
            end
            pace();
        end
    endtask

    initial
    begin : stimulus
        int p;
        int phase_goal;
        bit drained_once;
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.operation = OP_START;
        sample_bus.target_degrees = '0;
        sample_bus.rate_z = '0;
        sample_bus.time_ms = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_FULL_SPEED;
        cfg_bus.data = '0;
        holdoff_req = 0;
        burst_left = 0;
        now_ms = '0;
        drained_once = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle sample dropped, start within tolerance, zero drive
        send_word(OP_SAMPLE, '1, RateMax, 32'd5);
        send_word(OP_START, '0, '0, 32'd100);
        send_word(OP_START, '1, RateMax, 32'hFFFF_FFF0);
        send_word(OP_SAMPLE, '0, '0, 32'hFFFF_FFF0);
        wait_drained();

        write_reg(CFG_FULL_SPEED, 16'd700);
        write_reg(CFG_CORR_SPEED, 16'd150);
        write_reg(CFG_SLOW_ZONE, 16'd10);
        write_reg(CFG_DONE_TOL, 16'd1);
        write_reg(CFG_MIN_TURN_MS, 16'd20);
        // Wrapping clock, saturated delta, backward stamp
        send_word(OP_START, '1, RateMin, 32'hFFFF_FFF0);
        send_word(OP_SAMPLE, '0, RateMax, 32'h0000_0010);
        send_word(OP_SAMPLE, '0, RateMax, 32'h0000_0010 + 32'd100000);
        send_word(OP_SAMPLE, '0, RateMin, 32'h0000_0010 + 32'd99995);
        send_word(OP_SAMPLE, '0, '0, 32'h0000_0010 + 32'd99998);
        // Zero error before the minimum time, then finish, then an idle sample
        send_word(OP_START, '0, '0, 32'd5000);
        send_word(OP_SAMPLE, '0, '0, 32'd5001);
        send_word(OP_SAMPLE, '0, '0, 32'd5020);
        send_word(OP_SAMPLE, '0, '0, 32'd5030);
        // Within tolerance but the minimum time still holds the turn open
        send_word(OP_START, 10'd1, 20'sd500, 32'd6000);
        // Rounding ties both ways, small correction drive
        send_word(OP_START, 10'd5, 20'sd500, 32'd7000);
        send_word(OP_SAMPLE, '0, 20'sd500, 32'd7001);
        send_word(OP_SAMPLE, '0, -20'sd1500, 32'd7002);
        send_word(OP_SAMPLE, '0, 20'sd499, 32'd7003);
        send_word(OP_SAMPLE, '0, 20'sd499, 32'd7005);
        // Far from target: full drive
        send_word(OP_START, '1, '0, 32'd8000);
        send_word(OP_SAMPLE, '0, '0, 32'd8001);
        wait_drained();

        for (p = 0; p < PhaseCount; p++)
        begin
            program_phase(p);
            now_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
            if (p == 3)
            begin
                // Stall the output for a long stretch while starts keep coming
                holdoff_req = 300;
                repeat (64)
                    send_word(OP_START, DegW'($urandom), RateW'($urandom), $urandom);
            end
            if (p == 2)
                run_turn(80, 1);
            if (p == 5)
                run_turn(80, -1);
            phase_goal = pred.n_results + ResultsPerPhase;
            while (pred.n_results < phase_goal)
            begin
                run_turn($urandom_range(4, 40), 0);
                if (p == 4 && !drained_once && pred.n_results > phase_goal - ResultsPerPhase / 2)
                begin
                    wait_drained();
                    drained_once = 1'b1;
                end
            end
            wait_drained();
        end

        if (pred.expected_drive_q.size() != 0)
            pred.report($sformatf("%0d result words never arrived",
                                  pred.expected_drive_q.size()));
        $display("covered %0d starts, %0d integrating samples, %0d ignored words, %0d finishes",
                 pred.n_starts, pred.n_samples, pred.n_ignored, pred.n_finished);
        $display("checked %0d result words over %0d register writes, %0d accumulator clips",
                 pred.n_checked, pred.n_writes, pred.n_clipped);
        if (pred.errors == 0)
            $display("tb_gyro_integrating_turn_controller_unit: PASS");
        else
            $display("tb_gyro_integrating_turn_controller_unit: FAIL");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #2_400_000;
        $display("timeout waiting on the block");
        $display("tb_gyro_integrating_turn_controller_unit: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gitc_pkg.sv
hdl/gitc_ifs.sv
hdl/gyro_integrating_turn_controller_unit.sv
dv/tb_gyro_integrating_turn_controller_unit.sv
